>>> rtl/depth_test_zbuffer_assert.svh
// Assertion helpers for the depth test block; clk_i and rst_ni must be in scope.
`ifndef DEPTH_TEST_ZBUFFER_ASSERT_SVH
`define DEPTH_TEST_ZBUFFER_ASSERT_SVH

`define DTZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen at a clock edge
`define DTZ_NEVER(lbl, cond, msg) \
  `DTZ_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/dtz_pkg.sv
`timescale 1ns / 1ps

package dtz_pkg;

  localparam int unsigned SRC_W      = 16;
  localparam int unsigned BASE_W     = 16;
  localparam int unsigned PIX_W      = 10;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned MASK_W     = 16;
  // base + y*stride + x stays below 2^24 for all field values
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [1:0] {
    MODE_NEVER   = 2'd0,
    MODE_LESS    = 2'd1,
    MODE_GREATER = 2'd2,
    MODE_ALWAYS  = 2'd3
  } dtz_mode_e;

  typedef enum logic {
    CMD_TEST = 1'b0,
    CMD_LOAD = 1'b1
  } dtz_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPARE_MODE = 2'd0,
    CFG_WRITE_ENABLE = 2'd1,
    CFG_ROW_STRIDE   = 2'd2
  } dtz_cfg_idx_e;

  typedef struct packed {
    dtz_mode_e           mode;
    logic                write_en;
    logic [STRIDE_W-1:0] stride;
  } dtz_cfg_t;

  typedef struct packed {
    logic     valid;
    dtz_cmd_e cmd;
    logic     last;
  } dtz_ctl_t;

  localparam dtz_cfg_t CFG_RESET = '{
    mode:     MODE_LESS,
    write_en: 1'b1,
    stride:   STRIDE_W'(256)
  };

endpackage

>>> rtl/dtz_if.sv
`timescale 1ns / 1ps

interface dtz_pix_if;
  import dtz_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [BASE_W-1:0]        region_base;
  logic [PIX_W-1:0]         pixel_x;
  logic [PIX_W-1:0]         pixel_y;
  logic signed [SRC_W-1:0]  source_depth;
  logic                     last_pixel;

  modport source (
    output valid, command, region_base, pixel_x, pixel_y, source_depth, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, command, region_base, pixel_x, pixel_y, source_depth, last_pixel,
    output ready
  );
endinterface

interface dtz_res_if;
  import dtz_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MASK_W-1:0] mask_value;
  logic                     last;

  modport source (
    output valid, mask_value, last,
    input  ready
  );

  modport sink (
    input  valid, mask_value, last,
    output ready
  );
endinterface

>>> rtl/dtz_ram.sv
`timescale 1ns / 1ps

module dtz_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dtz_addr_gen.sv
`timescale 1ns / 1ps

module dtz_addr_gen #(
  parameter int unsigned STORE_WORDS = 65536,
  localparam int unsigned ADDR_W = $clog2(STORE_WORDS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [dtz_pkg::STRIDE_W-1:0]   stride_i,
  input  dtz_pkg::dtz_ctl_t              ctl_i,
  input  logic [dtz_pkg::BASE_W-1:0]     base_i,
  input  logic [dtz_pkg::PIX_W-1:0]      px_i,
  input  logic [dtz_pkg::PIX_W-1:0]      py_i,
  input  logic [dtz_pkg::SRC_W-1:0]      src_i,
  output dtz_pkg::dtz_ctl_t              ctl_o,
  output logic [dtz_pkg::SRC_W-1:0]      src_o,
  output logic [ADDR_W-1:0]              addr_o
);
  import dtz_pkg::*;

  localparam int unsigned STAGES      = 5;
  localparam int unsigned PROD_W      = PIX_W + STRIDE_W;
  // reduction mod STORE_WORDS: quotient estimate by reciprocal, then one correction
  localparam int unsigned RECIP_SHIFT = SUM_W + ADDR_W;
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned MUL_W       = SUM_W + RECIP_W;
  localparam int unsigned QUOT_W      = SUM_W - ADDR_W + 1;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(STORE_WORDS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [SUM_W:0] WORDS_C  = (SUM_W + 1)'(STORE_WORDS);
  localparam logic [SUM_W-1:0] WORDS_S = SUM_W'(STORE_WORDS);

  dtz_ctl_t          ctl_q [STAGES];
  logic [SRC_W-1:0]  src_q [STAGES];

  logic [PROD_W-1:0] prod_q, prod_d;
  logic [BASE_W-1:0] base_q;
  logic [PIX_W-1:0]  px_q, px_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  sum3_q, sum4_q;
  logic [MUL_W-1:0]  recip_q, recip_d;
  logic [QUOT_W-1:0] quot;
  logic [SUM_W-1:0]  qc_q, qc_d;
  logic [SUM_W-1:0]  rem, rem_adj;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              is_load;

  always_comb begin
    is_load = (ctl_i.cmd == CMD_LOAD);
    // a load goes to region_base alone
    prod_d  = is_load ? '0 : PROD_W'(py_i) * PROD_W'(stride_i);
    px_d    = is_load ? '0 : px_i;
    sum_d   = SUM_W'(base_q) + SUM_W'(prod_q) + SUM_W'(px_q);
    recip_d = MUL_W'(sum_q) * MUL_W'(RECIP);
    quot    = recip_q[RECIP_SHIFT +: QUOT_W];
    qc_d    = SUM_W'((SUM_W + 1)'(quot) * WORDS_C);
    rem     = sum4_q - qc_q;
    rem_adj = (rem >= WORDS_S) ? rem - WORDS_S : rem;
    addr_d  = rem_adj[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_q[0] <= src_i;
      for (int i = 1; i < STAGES; i++) begin
        src_q[i] <= src_q[i-1];
      end
      prod_q  <= prod_d;
      base_q  <= base_i;
      px_q    <= px_d;
      sum_q   <= sum_d;
      sum3_q  <= sum_q;
      recip_q <= recip_d;
      sum4_q  <= sum3_q;
      qc_q    <= qc_d;
      addr_q  <= addr_d;
    end
  end

  assign ctl_o  = ctl_q[STAGES-1];
  assign src_o  = src_q[STAGES-1];
  assign addr_o = addr_q;

endmodule

>>> rtl/dtz_depth_unit.sv
`timescale 1ns / 1ps
`include "depth_test_zbuffer_assert.svh"

module dtz_depth_unit #(
  parameter int unsigned STORE_WORDS = 65536,
  parameter int unsigned DEPTH_BITS  = 16,
  localparam int unsigned ADDR_W = $clog2(STORE_WORDS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  dtz_pkg::dtz_cfg_t           cfg_i,
  input  dtz_pkg::dtz_ctl_t           ctl_i,
  input  logic [dtz_pkg::SRC_W-1:0]   src_i,
  input  logic [ADDR_W-1:0]           addr_i,
  output dtz_pkg::dtz_ctl_t           ctl_o,
  output logic [dtz_pkg::MASK_W-1:0]  mask_o
);
  import dtz_pkg::*;

  dtz_ctl_t              ctl_q;
  logic [SRC_W-1:0]      src_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  fwd_valid_q, fwd_valid_d;
  logic [DEPTH_BITS-1:0] fwd_data_q;
  logic [DEPTH_BITS-1:0] rdata;
  logic [DEPTH_BITS-1:0] src_w;
  logic [DEPTH_BITS-1:0] stored;
  logic [DEPTH_BITS-1:0] mask;
  logic                  pass;
  logic                  is_load;
  logic                  wr_en;
  logic                  rd_en;

  assign rd_en = en_i && ctl_i.valid;

  dtz_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr_q),
    .wdata_i (src_w),
    .re_i    (rd_en),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_comb begin
    is_load = (ctl_q.cmd == CMD_LOAD);
    src_w   = DEPTH_BITS'(signed'(src_q));
    // write from the transaction ahead lands on the same edge as our read
    stored  = fwd_valid_q ? fwd_data_q : rdata;
    mask    = '0;
    pass    = 1'b0;
    case (cfg_i.mode)
      MODE_NEVER: begin
        mask = '0;
        pass = 1'b0;
      end
      MODE_LESS: begin
        mask = src_w - stored;
        pass = mask[DEPTH_BITS-1];
      end
      MODE_GREATER: begin
        mask = stored - src_w;
        pass = mask[DEPTH_BITS-1];
      end
      MODE_ALWAYS: begin
        mask = '1;
        pass = 1'b1;
      end
      default: begin
        mask = '0;
        pass = 1'b0;
      end
    endcase
    wr_en       = en_i && ctl_q.valid && (is_load || (pass && cfg_i.write_en));
    fwd_valid_d = wr_en && ctl_i.valid && (addr_q == addr_i);
    mask_o      = is_load ? '0 : MASK_W'(mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      fwd_valid_q <= 1'b0;
    end else if (en_i) begin
      ctl_q       <= ctl_i;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_q      <= src_i;
      addr_q     <= addr_i;
      fwd_data_q <= src_w;
    end
  end

  assign ctl_o = ctl_q;

  `DTZ_ASSERT(a_fwd_has_item, fwd_valid_q |-> ctl_q.valid, "forward flag without an item")

endmodule

>>> rtl/depth_test_zbuffer.sv
// Throughput: one transaction per clock while the skid entry is free; the
// store is one RAM with a read and a write port, read-modify-write
// pipelined with one-deep forwarding.
// A two-entry output buffer keeps input open while one result waits.
// Reset (rst_ni, async, active low) empties the pipeline and loads register
// defaults; the depth store is not cleared and has no clearing pass.
`timescale 1ns / 1ps
`include "depth_test_zbuffer_assert.svh"

module depth_test_zbuffer #(
  parameter int unsigned STORE_WORDS = 65536,
  parameter int unsigned DEPTH_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dtz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dtz_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dtz_pix_if.sink                        pix_i,
  dtz_res_if.source                      res_o
);
  import dtz_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_WORDS);

  dtz_cfg_t          cfg_q, cfg_d;
  dtz_ctl_t          in_ctl;
  dtz_ctl_t          ag_ctl, du_ctl;
  logic [SRC_W-1:0]  ag_src;
  logic [ADDR_W-1:0] ag_addr;
  logic [MASK_W-1:0] du_mask;
  logic              en;
  logic              push, pop;

  logic              main_valid_q, main_valid_d;
  logic [MASK_W-1:0] main_mask_q, main_mask_d;
  logic              main_last_q, main_last_d;
  logic              skid_valid_q, skid_valid_d;
  logic [MASK_W-1:0] skid_mask_q, skid_mask_d;
  logic              skid_last_q, skid_last_d;

  // configuration
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COMPARE_MODE: cfg_d.mode     = dtz_mode_e'(cfg_data_i[1:0]);
        CFG_WRITE_ENABLE: cfg_d.write_en = cfg_data_i[0];
        CFG_ROW_STRIDE:   cfg_d.stride   = cfg_data_i[STRIDE_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // whole pipeline moves while the skid entry is free
  assign en          = !skid_valid_q;
  assign pix_i.ready = en;

  always_comb begin
    in_ctl.valid = pix_i.valid;
    in_ctl.cmd   = dtz_cmd_e'(pix_i.command);
    in_ctl.last  = pix_i.last_pixel;
  end

  dtz_addr_gen #(
    .STORE_WORDS (STORE_WORDS)
  ) u_addr_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .stride_i (cfg_q.stride),
    .ctl_i    (in_ctl),
    .base_i   (pix_i.region_base),
    .px_i     (pix_i.pixel_x),
    .py_i     (pix_i.pixel_y),
    .src_i    (pix_i.source_depth),
    .ctl_o    (ag_ctl),
    .src_o    (ag_src),
    .addr_o   (ag_addr)
  );

  dtz_depth_unit #(
    .STORE_WORDS (STORE_WORDS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_depth_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .ctl_i  (ag_ctl),
    .src_i  (ag_src),
    .addr_i (ag_addr),
    .ctl_o  (du_ctl),
    .mask_o (du_mask)
  );

  // output register with skid entry
  assign push = en && du_ctl.valid;
  assign pop  = main_valid_q && res_o.ready;

  always_comb begin
    main_valid_d = main_valid_q;
    main_mask_d  = main_mask_q;
    main_last_d  = main_last_q;
    skid_valid_d = skid_valid_q;
    skid_mask_d  = skid_mask_q;
    skid_last_d  = skid_last_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_mask_d  = skid_mask_q;
        main_last_d  = skid_last_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_valid_d = 1'b1;
        main_mask_d  = du_mask;
        main_last_d  = du_ctl.last;
      end else begin
        skid_valid_d = 1'b1;
        skid_mask_d  = du_mask;
        skid_last_d  = du_ctl.last;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_mask_q <= main_mask_d;
    main_last_q <= main_last_d;
    skid_mask_q <= skid_mask_d;
    skid_last_q <= skid_last_d;
  end

  assign res_o.valid      = main_valid_q;
  assign res_o.mask_value = main_mask_q;
  assign res_o.last       = main_last_q;

  `DTZ_NEVER(a_skid_without_main, skid_valid_q && !main_valid_q, "skid entry ahead of output")
  `DTZ_ASSERT(a_skid_fill, $rose(skid_valid_q) |-> $past(main_valid_q && !res_o.ready), "skid filled while output free")

endmodule
